// File: rtl/msbbrw_pkg.sv
`timescale 1ns / 1ps
// msbbrw_pkg: shared types, operation and status codes, field widths
// and parameter defaults for the msb-first bit reader/writer.
// no dependencies.
package msbbrw_pkg;

  // parameter defaults
  localparam int BUFFER_BYTES_DEF   = 4096;
  localparam int MAX_FIELD_BITS_DEF = 32;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 13;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_REWIND = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SKIP   = 3'd4,
    OP_ALIGN  = 3'd5,
    OP_PEEK   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_COUNT = 2'd2
  } status_t;

  // low n bits set, n up to the full value width
  function automatic logic [VALUE_W-1:0] low_mask(input logic [5:0] n);
    logic [VALUE_W:0] m;
    m = ({{VALUE_W{1'b0}}, 1'b1} << n) - {{VALUE_W{1'b0}}, 1'b1};
    return m[VALUE_W-1:0];
  endfunction

endpackage

// File: rtl/msbbrw_ram.sv
`timescale 1ns / 1ps
// msbbrw_ram: generic single-port ram with registered read data.
// no dependencies.
module msbbrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/msb_first_bit_reader_writer.sv
`timescale 1ns / 1ps
// msb_first_bit_reader_writer: byte store with an msb-first bit cursor.
// depends on msbbrw_pkg and msbbrw_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | op, load_address, load_byte,
//          |           |                    | bit_count, write_value
//  out_    | output    | out_valid/out_stall| read_value, bit_position, at_end,
//          |           |                    | status
//  cfg_    | input     | cfg_valid/cfg_ready| buffer_length
//
// one word at a time: load, rewind, skip, align, no-op, a zero count and any word
// that fails at once go from setup straight to the result; a read fetches each byte
// touched while it takes the one before; a write does a read-modify-write of each
// byte touched on the single port of the byte store. peek reads one byte.
// rst_n is synchronous; it clears the cursor and the length, not the store.
// in_stall is high from accept until the result is handed to the output
// register; a stalled result holds the block in its final state.
module msb_first_bit_reader_writer #(
  parameter int BUFFER_BYTES   = msbbrw_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = msbbrw_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msbbrw_pkg::OP_W-1:0]       in_op,
  input  logic [msbbrw_pkg::ADDR_W-1:0]     in_load_address,
  input  logic [msbbrw_pkg::BYTE_W-1:0]     in_load_byte,
  input  logic [msbbrw_pkg::COUNT_W-1:0]    in_bit_count,
  input  logic [msbbrw_pkg::VALUE_W-1:0]    in_write_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msbbrw_pkg::VALUE_W-1:0]    out_read_value,
  output logic [msbbrw_pkg::POS_W-1:0]      out_bit_position,
  output logic                              out_at_end,
  output logic [msbbrw_pkg::STATUS_W-1:0]   out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msbbrw_pkg::LEN_W-1:0]      cfg_buffer_length
);

  import msbbrw_pkg::*;

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int IDX_W = AW + 1;
  localparam int CW    = IDX_W + 3;
  localparam int NW    = $clog2(MAX_FIELD_BITS + 1);
  localparam int NB    = (MAX_FIELD_BITS + 14) / 8;
  localparam int WIN_W = NB * 8;
  localparam int SW    = $clog2(WIN_W + 1);
  localparam int NBW   = $clog2(NB + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PREP,
    S_RD_ISSUE,
    S_RD_TAKE,
    S_RD_FINISH,
    S_WR_ISSUE,
    S_WR_MERGE,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic [IDX_W-1:0]      end_r, end_nxt;
  op_t                   op_r, op_nxt;
  logic [ADDR_W-1:0]     load_addr_r, load_addr_nxt;
  logic [BYTE_W-1:0]     load_byte_r, load_byte_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [VALUE_W-1:0]    wval_r, wval_nxt;
  logic [VALUE_W-1:0]    value_r, value_nxt;
  status_t               status_r, status_nxt;
  logic [2:0]            off_r, off_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [NBW-1:0]        nb_r, nb_nxt;
  logic [NBW-1:0]        nbt_r, nbt_nxt;
  logic [AW-1:0]         baddr_r, baddr_nxt;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [WIN_W-1:0]      mwin_r, mwin_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_read_value_r, out_read_value_nxt;
  logic [POS_W-1:0]      out_bit_position_r, out_bit_position_nxt;
  logic                  out_at_end_r, out_at_end_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  ram_en;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [BYTE_W-1:0]     ram_wdata;
  logic [BYTE_W-1:0]     ram_rdata;

  // cursor view
  logic [IDX_W-1:0]      byte_idx;
  logic                  past_end;
  logic [CW-1:0]         rem_bits;
  logic                  count_big;
  logic                  count_over;
  logic [CW-1:0]         end_bits;
  logic [SW-1:0]         nb_sum;
  logic [SW-1:0]         place_sh;
  logic [SW-1:0]         take_sh;
  logic [NW-1:0]         drop_sh;
  logic [VALUE_W-1:0]    field_bits;
  logic [BYTE_W-1:0]     merged;

  assign byte_idx   = cur_r[CW-1:3];
  assign past_end   = (byte_idx >= end_r);
  assign end_bits   = {end_r, 3'b000};
  assign rem_bits   = past_end ? '0 : (end_bits - cur_r);
  assign count_big  = (count_r > COUNT_W'(MAX_FIELD_BITS));
  assign count_over = (32'(count_r) > 32'(rem_bits));
  assign nb_sum     = SW'(cur_r[2:0]) + SW'(count_r[NW-1:0]) + SW'(7);

  assign place_sh   = SW'(WIN_W) - SW'(off_r) - SW'(n_r);
  assign take_sh    = SW'({nbt_r, 3'b000}) - SW'(off_r) - SW'(n_r);
  assign drop_sh    = count_r[NW-1:0] - n_r;
  assign field_bits = (wval_r >> drop_sh) & low_mask(6'(n_r));
  assign merged     = (ram_rdata & ~mwin_r[WIN_W-1 -: 8])
                    | (win_r[WIN_W-1 -: 8] & mwin_r[WIN_W-1 -: 8]);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt            = state_r;
    cur_nxt              = cur_r;
    end_nxt              = end_r;
    op_nxt               = op_r;
    load_addr_nxt        = load_addr_r;
    load_byte_nxt        = load_byte_r;
    count_nxt            = count_r;
    wval_nxt             = wval_r;
    value_nxt            = value_r;
    status_nxt           = status_r;
    off_nxt              = off_r;
    n_nxt                = n_r;
    nb_nxt               = nb_r;
    nbt_nxt              = nbt_r;
    baddr_nxt            = baddr_r;
    win_nxt              = win_r;
    mwin_nxt             = mwin_r;
    out_valid_nxt        = out_valid_r;
    out_read_value_nxt   = out_read_value_r;
    out_bit_position_nxt = out_bit_position_r;
    out_at_end_nxt       = out_at_end_r;
    out_status_nxt       = out_status_r;
    ram_en               = 1'b0;
    ram_we               = 1'b0;
    ram_addr             = baddr_r;
    ram_wdata            = merged;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (32'(cfg_buffer_length) > 32'(BUFFER_BYTES)) begin
        end_nxt = IDX_W'(BUFFER_BYTES);
      end else begin
        end_nxt = IDX_W'(cfg_buffer_length);
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = op_t'(in_op);
          load_addr_nxt = in_load_address;
          load_byte_nxt = in_load_byte;
          count_nxt     = in_bit_count;
          wval_nxt      = in_write_value;
          state_nxt     = S_SETUP;
        end
      end

      S_SETUP: begin
        value_nxt  = '0;
        status_nxt = ST_OK;
        off_nxt    = cur_r[2:0];
        baddr_nxt  = AW'(byte_idx);
        win_nxt    = '0;
        state_nxt  = S_DONE;
        unique case (op_r)
          OP_LOAD: begin
            if (32'(load_addr_r) < 32'(BUFFER_BYTES)) begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = AW'(load_addr_r);
              ram_wdata = load_byte_r;
            end
          end
          OP_REWIND: begin
            cur_nxt = '0;
          end
          OP_READ: begin
            if (count_big) begin
              status_nxt = ST_COUNT;
            end else if (count_over) begin
              status_nxt = ST_END;
              if (!past_end) begin
                cur_nxt = end_bits;
              end
            end else if (count_r != '0) begin
              n_nxt     = count_r[NW-1:0];
              nb_nxt    = NBW'(nb_sum >> 3);
              nbt_nxt   = NBW'(nb_sum >> 3);
              cur_nxt   = cur_r + CW'(count_r[NW-1:0]);
              state_nxt = S_RD_ISSUE;
            end
          end
          OP_WRITE: begin
            if (count_big) begin
              status_nxt = ST_COUNT;
            end else begin
              // bits that fit before the end; the rest are dropped
              if (count_over) begin
                status_nxt = ST_END;
                n_nxt      = NW'(rem_bits);
                nb_nxt     = NBW'((SW'(cur_r[2:0]) + SW'(NW'(rem_bits)) + SW'(7)) >> 3);
                cur_nxt    = cur_r + rem_bits;
                if (rem_bits != '0) begin
                  state_nxt = S_PREP;
                end
              end else begin
                n_nxt   = count_r[NW-1:0];
                nb_nxt  = NBW'(nb_sum >> 3);
                cur_nxt = cur_r + CW'(count_r[NW-1:0]);
                if (count_r != '0) begin
                  state_nxt = S_PREP;
                end
              end
            end
          end
          OP_SKIP: begin
            if (count_over) begin
              status_nxt = ST_END;
              if (!past_end) begin
                cur_nxt = end_bits;
              end
            end else begin
              cur_nxt = cur_r + CW'(count_r);
            end
          end
          OP_ALIGN: begin
            if (cur_r[2:0] != 3'd0) begin
              cur_nxt = {byte_idx + IDX_W'(1), 3'b000};
            end
          end
          OP_PEEK: begin
            if (rem_bits == '0) begin
              status_nxt = ST_END;
            end else begin
              n_nxt     = NW'(1);
              nb_nxt    = NBW'(1);
              nbt_nxt   = NBW'(1);
              state_nxt = S_RD_ISSUE;
            end
          end
          OP_NOP: begin
          end
          default: begin
          end
        endcase
      end

      S_PREP: begin
        // line the field and its mask up with the cursor's bit offset in the first byte of the window
        win_nxt   = WIN_W'(field_bits) << place_sh;
        mwin_nxt  = WIN_W'(low_mask(6'(n_r))) << place_sh;
        state_nxt = S_WR_ISSUE;
      end

      S_RD_ISSUE: begin
        ram_en    = 1'b1;
        baddr_nxt = baddr_r + AW'(1);
        state_nxt = S_RD_TAKE;
      end

      S_RD_TAKE: begin
        win_nxt = {win_r[WIN_W-9:0], ram_rdata};
        nb_nxt  = nb_r - NBW'(1);
        if (nb_r == NBW'(1)) begin
          state_nxt = S_RD_FINISH;
        end else begin
          // next byte overlaps with taking this one
          ram_en    = 1'b1;
          baddr_nxt = baddr_r + AW'(1);
        end
      end

      S_RD_FINISH: begin
        value_nxt = 32'(win_r >> take_sh) & low_mask(6'(n_r));
        state_nxt = S_DONE;
      end

      S_WR_ISSUE: begin
        ram_en    = 1'b1;
        state_nxt = S_WR_MERGE;
      end

      S_WR_MERGE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        win_nxt   = win_r << 8;
        mwin_nxt  = mwin_r << 8;
        baddr_nxt = baddr_r + AW'(1);
        nb_nxt    = nb_r - NBW'(1);
        if (nb_r == NBW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WR_ISSUE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_read_value_nxt   = value_r;
          out_bit_position_nxt = POS_W'(cur_r);
          out_at_end_nxt       = past_end;
          out_status_nxt       = status_r;
          state_nxt            = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r               <= op_nxt;
    load_addr_r        <= load_addr_nxt;
    load_byte_r        <= load_byte_nxt;
    count_r            <= count_nxt;
    wval_r             <= wval_nxt;
    value_r            <= value_nxt;
    status_r           <= status_nxt;
    off_r              <= off_nxt;
    n_r                <= n_nxt;
    nb_r               <= nb_nxt;
    nbt_r              <= nbt_nxt;
    baddr_r            <= baddr_nxt;
    win_r              <= win_nxt;
    mwin_r             <= mwin_nxt;
    out_read_value_r   <= out_read_value_nxt;
    out_bit_position_r <= out_bit_position_nxt;
    out_at_end_r       <= out_at_end_nxt;
    out_status_r       <= out_status_nxt;
  end

  msbbrw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_value_r;
  assign out_bit_position = out_bit_position_r;
  assign out_at_end       = out_at_end_r;
  assign out_status       = out_status_r;

endmodule

// File: sim/msb_first_bit_reader_writer_tb.sv
`timescale 1ns / 1ps
// msb_first_bit_reader_writer_tb: self-checking bench for the msb-first bit reader/writer.
// depends on msbbrw_pkg and the rtl of msb_first_bit_reader_writer; runs directed words,
// then random words over several buffer lengths, and checks every result word.
module msb_first_bit_reader_writer_tb;
  import msbbrw_pkg::*;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  wval;
  } bit_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
    logic                at_end;
    status_t             status;
  } cursor_report_t;

  // tracks the byte store and the bit cursor, and the reports still owed by the block
  class bitstream_scoreboard;
    logic [BYTE_W-1:0] store [BUFFER_BYTES_DEF];
    bit                loaded [BUFFER_BYTES_DEF];
    logic [LEN_W-1:0]  length   = '0;
    logic [LEN_W-1:0]  cur_byte = '0;
    logic [3:0]        cur_left = 4'd8;
    cursor_report_t    awaited_reports [$];
    int unsigned       failures = 0;

    function int end_bytes();
      return (length > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : int'(length);
    endfunction

    function int cursor();
      return int'(cur_byte) * 8 + 8 - int'(cur_left);
    endfunction

    function int bits_available();
      if (int'(cur_byte) >= end_bytes()) return 0;
      return end_bytes() * 8 - cursor();
    endfunction

    function logic current_bit();
      return store[cur_byte][cur_left - 4'd1];
    endfunction

    function void advance();
      cur_left = cur_left - 4'd1;
      if (cur_left == 4'd0) begin
        cur_byte = cur_byte + 1'b1;
        cur_left = 4'd8;
      end
    endfunction

    function void jump_to_end();
      if (int'(cur_byte) < end_bytes()) begin
        cur_byte = LEN_W'(end_bytes());
        cur_left = 4'd8;
      end
    endfunction

    function cursor_report_t predict(bit_cmd_t w);
      cursor_report_t r;
      int cnt;
      int np;
      int pending_bits;
      r = '0;
      cnt = int'(w.count);
      case (w.op)
        OP_LOAD: begin
          store[w.addr] = w.data;
          loaded[w.addr] = 1'b1;
        end
        OP_REWIND: begin
          cur_byte = '0;
          cur_left = 4'd8;
        end
        OP_READ: begin
          if (cnt > MAX_FIELD_BITS_DEF) begin
            r.status = ST_COUNT;
          end else if (cnt > bits_available()) begin
            jump_to_end();
            r.status = ST_END;
          end else begin
            for (int i = 0; i < cnt; i++) begin
              r.value = {r.value[VALUE_W-2:0], current_bit()};
              advance();
            end
          end
        end
        OP_WRITE: begin
          if (cnt > MAX_FIELD_BITS_DEF) begin
            r.status = ST_COUNT;
          end else begin
            pending_bits = cnt;
            // msb of the field goes first; bits beyond the end are dropped
            while (pending_bits > 0) begin
              if (int'(cur_byte) >= end_bytes()) begin
                r.status = ST_END;
                break;
              end
              pending_bits--;
              store[cur_byte][cur_left - 4'd1] = w.wval[pending_bits];
              advance();
            end
          end
        end
        OP_SKIP: begin
          if (cnt > bits_available()) begin
            jump_to_end();
            r.status = ST_END;
          end else begin
            np = cursor() + cnt;
            cur_byte = LEN_W'(np / 8);
            cur_left = 4'(8 - np % 8);
          end
        end
        OP_ALIGN: begin
          if (cur_left != 4'd8) begin
            cur_left = 4'd8;
            cur_byte = cur_byte + 1'b1;
          end
        end
        OP_PEEK: begin
          if (bits_available() == 0) r.status = ST_END;
          else r.value = {{(VALUE_W-1){1'b0}}, current_bit()};
        end
        default: ;
      endcase
      r.position = POS_W'(cursor());
      r.at_end   = (int'(cur_byte) >= end_bytes());
      return r;
    endfunction

    function void accept_word(bit_cmd_t w);
      awaited_reports.push_back(predict(w));
    endfunction

    function void check_word(cursor_report_t got);
      cursor_report_t want;
      if (awaited_reports.size() == 0) begin
        $error("result word with nothing expected: value %h position %0d", got.value,
               got.position);
        failures++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.value !== want.value) begin
        $error("read_value: expected %h, got %h", want.value, got.value);
        failures++;
      end
      if (got.position !== want.position) begin
        $error("bit_position: expected %0d, got %0d", want.position, got.position);
        failures++;
      end
      if (got.at_end !== want.at_end) begin
        $error("at_end: expected %b, got %b", want.at_end, got.at_end);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  localparam logic [LEN_W-1:0] PHASE_LENGTHS [8] = '{16, 1, 4096, 37, 8191, 0, 3, 64};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = '0;
  logic [ADDR_W-1:0]    in_load_address = '0;
  logic [BYTE_W-1:0]    in_load_byte = '0;
  logic [COUNT_W-1:0]   in_bit_count = '0;
  logic [VALUE_W-1:0]   in_write_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_read_value;
  logic [POS_W-1:0]     out_bit_position;
  logic                 out_at_end;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LEN_W-1:0]     cfg_buffer_length = '0;

  bit                   calm = 1'b0;
  int unsigned          gap_pct = 0;
  int unsigned          stall_pct = 0;
  bitstream_scoreboard  sb = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  msb_first_bit_reader_writer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_load_address   (in_load_address),
    .in_load_byte      (in_load_byte),
    .in_bit_count      (in_bit_count),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_bit_position  (out_bit_position),
    .out_at_end        (out_at_end),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_buffer_length (cfg_buffer_length)
  );

  task automatic push_word(bit_cmd_t w);
    in_valid        <= 1'b1;
    in_op           <= w.op;
    in_load_address <= w.addr;
    in_load_byte    <= w.data;
    in_bit_count    <= w.count;
    in_write_value  <= w.wval;
    do @(posedge clk); while (in_stall);
    sb.accept_word(w);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic store_byte(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    bit_cmd_t w;
    w.op    = OP_LOAD;
    w.addr  = addr;
    w.data  = data;
    w.count = COUNT_W'($urandom);
    w.wval  = $urandom;
    push_word(w);
  endtask

  // unused fields carry noise; store bytes the word will touch are loaded first
  task automatic do_op(op_t op, logic [COUNT_W-1:0] count = '0,
                       logic [VALUE_W-1:0] wval = '0);
    bit_cmd_t w;
    int cnt;
    int lo_byte;
    int hi_byte;
    cnt     = int'(count);
    lo_byte = int'(sb.cur_byte);
    hi_byte = -1;
    if (op == OP_READ && cnt != 0 && cnt <= MAX_FIELD_BITS_DEF && cnt <= sb.bits_available())
      hi_byte = (sb.cursor() + cnt - 1) / 8;
    else if (op == OP_PEEK && sb.bits_available() != 0)
      hi_byte = lo_byte;
    else if (op == OP_WRITE && cnt != 0 && cnt <= MAX_FIELD_BITS_DEF &&
             lo_byte < sb.end_bytes()) begin
      hi_byte = (sb.cursor() + cnt - 1) / 8;
      if (hi_byte > sb.end_bytes() - 1) hi_byte = sb.end_bytes() - 1;
    end
    for (int b = lo_byte; b <= hi_byte; b++)
      if (!sb.loaded[b]) store_byte(ADDR_W'(b), BYTE_W'($urandom));
    w.op    = op;
    w.addr  = ADDR_W'($urandom);
    w.data  = BYTE_W'($urandom);
    w.count = count;
    w.wval  = wval;
    push_word(w);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.awaited_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    drain();
    cfg_valid         <= 1'b1;
    cfg_buffer_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.length = len;
  endtask

  initial begin : result_side
    cursor_report_t got;
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.value    = out_read_value;
        got.position = out_bit_position;
        got.at_end   = out_at_end;
        got.status   = status_t'(out_status);
        sb.check_word(got);
      end
      if (hold != 0) hold--;
      else if (!calm && $urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 8);
      out_stall <= (hold != 0);
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int left;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty buffer: nonzero reads, peek, skip and writes run into the end; over-long counts fail on the count
    set_length('0);
    do_op(OP_READ, 16'd0);
    do_op(OP_READ, 16'd1);
    do_op(OP_PEEK);
    do_op(OP_SKIP, 16'd9);
    do_op(OP_WRITE, 16'd5, 32'hFFFF_FFFF);
    do_op(OP_READ, 16'd33);
    do_op(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    do_op(OP_NOP);
    store_byte(12'hFFF, 8'hFF);

    set_length(13'd4);
    store_byte(12'd0, 8'hA5);
    store_byte(12'd1, 8'h3C);
    store_byte(12'd2, 8'hFF);
    store_byte(12'd3, 8'h00);
    do_op(OP_READ, 16'd3);
    do_op(OP_PEEK);
    do_op(OP_ALIGN);
    do_op(OP_READ, 16'd32);
    do_op(OP_REWIND);
    do_op(OP_READ, 16'd32);
    do_op(OP_REWIND);
    do_op(OP_SKIP, 16'd7);
    do_op(OP_WRITE, 16'd32, 32'h0000_0000);
    do_op(OP_SKIP, 16'hFFFF);

    // cursor now lies beyond a shrunk buffer
    set_length(13'd1);
    do_op(OP_ALIGN);
    do_op(OP_PEEK);
    do_op(OP_SKIP, 16'd0);

    for (int p = 0; p < 8; p++) begin
      set_length(p == 5 ? LEN_W'($urandom_range(2, 300)) : PHASE_LENGTHS[p]);
      calm = (p == 7);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 45;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 45;
      endcase
      for (int k = 0; k < 190; k++) begin
        if (!calm && $urandom_range(0, 199) == 0) drain();
        pick = $urandom_range(0, 99);
        if (pick < 26)
          do_op(OP_READ, COUNT_W'($urandom_range(0, 32)), $urandom);
        else if (pick < 44)
          do_op(OP_WRITE, COUNT_W'($urandom_range(0, 32)), $urandom);
        else if (pick < 56)
          do_op(OP_SKIP, ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom) :
                         COUNT_W'($urandom_range(0, 40)), $urandom);
        else if (pick < 64)
          do_op(OP_PEEK, COUNT_W'($urandom), $urandom);
        else if (pick < 70)
          do_op(OP_ALIGN, COUNT_W'($urandom), $urandom);
        else if (pick < 75)
          do_op(OP_REWIND, COUNT_W'($urandom), $urandom);
        else if (pick < 84)
          do_op(OP_LOAD, COUNT_W'($urandom), $urandom);
        else if (pick < 90)
          do_op($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                COUNT_W'($urandom_range(33, 65535)), $urandom);
        else if (pick < 93)
          do_op(OP_NOP, COUNT_W'($urandom), $urandom);
        else begin
          // land exactly on the end or one bit past it
          left = sb.bits_available();
          do_op($urandom_range(0, 1) ? OP_READ : OP_SKIP,
                COUNT_W'(left + $urandom_range(0, 1)), $urandom);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.awaited_reports.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
rtl/msbbrw_pkg.sv
rtl/msbbrw_ram.sv
rtl/msb_first_bit_reader_writer.sv
sim/msb_first_bit_reader_writer_tb.sv
